// ===== design/printable_run_extractor_macros.svh =====
// assertion macros shared by the printable run extractor rtl
// expects signals named clock and reset in the module that uses them
`ifndef PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication checked in the same cycle
`define PRE_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("printable run extractor check failed");

// implication checked in the next cycle
`define PRE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("printable run extractor check failed");

`else

`define PRE_ASSERT(label, ante, cons)
`define PRE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/pre_pkg.sv =====
// shared constants, codes and types of the printable run extractor
// no dependencies
package pre_pkg;

   // sizing
   localparam int MAX_MIN_LEN = 32;
   localparam int OFFSET_BITS = 32;
   localparam int CNT_W       = $clog2(MAX_MIN_LEN + 1);
   localparam int IDX_W       = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
   localparam int MIN_LEN_W   = 6;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int OUT_OFF_W   = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_EN = 1'd1;

   // reset values
   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd4;

   // input op codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_EOS  = 1'b1;

   // result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_OFFSET = 1'b1;

   // characters
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;

   // control handed from the sequencer to the cell chain
   typedef struct packed {
      logic             load;
      logic             shift;
      logic [IDX_W-1:0] wr_idx;
      logic [CNT_W-1:0] len;
      logic [7:0]       data;
   } chain_ctrl_type;

   // printable test: space to tilde, plus tab
   function automatic logic is_printable(input logic [7:0] b);
      return ((b >= CHAR_SPACE) && (b <= CHAR_TILDE)) || (b == CHAR_TAB);
   endfunction

endpackage

// ===== design/pre_if.sv =====
// valid/ready channel interfaces of the printable run extractor
// depends on pre_pkg for field widths
interface pre_req_if
   import pre_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_value;

   modport source (output valid, output op, output byte_value, input ready);
   modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface pre_rsp_if
   import pre_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [7:0]           char_out;
   logic [OUT_OFF_W-1:0] start_offset;
   logic                 last;

   modport source (output valid, output kind, output char_out, output start_offset,
                   output last, input ready);
   modport sink   (input valid, input kind, input char_out, input start_offset,
                   input last, output ready);
endinterface

// ===== design/pre_cell.sv =====
// one byte cell of the held-byte chain
// loads a new byte or takes its neighbor's byte; depends on nothing
module pre_cell (
   input  logic       clock,
   input  logic       load_en,
   input  logic       shift_en,
   input  logic [7:0] load_byte,
   input  logic [7:0] next_byte,
   output logic [7:0] held_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // load wins over shift; they never meet in practice
   always_comb begin
      byte_in = byte_ff;
      if (load_en) begin
         byte_in = load_byte;
      end else if (shift_en) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;

endmodule

// ===== design/pre_chain.sv =====
// row of byte cells holding the start of the current run
// depends on pre_pkg and pre_cell
module pre_chain
   import pre_pkg::*;
(
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   output logic [7:0]     head_byte
);

   logic [7:0] held [MAX_MIN_LEN];

   // each cell rotates within the first len cells, the last one wraps to cell 0
   for (genvar i = 0; i < MAX_MIN_LEN; i++) begin : g_cell
      logic [7:0] nbr_byte;
      logic [7:0] next_byte;
      logic       load_en;
      logic       shift_en;

      if (i == MAX_MIN_LEN - 1) begin : g_tail
         assign nbr_byte = held[0];
      end else begin : g_mid
         assign nbr_byte = held[i+1];
      end

      assign next_byte = (ctrl.len == CNT_W'(i + 1)) ? held[0] : nbr_byte;
      assign load_en   = ctrl.load && (ctrl.wr_idx == IDX_W'(i));
      assign shift_en  = ctrl.shift && (CNT_W'(i) < ctrl.len);

      pre_cell u_cell (
         .clock     (clock),
         .load_en   (load_en),
         .shift_en  (shift_en),
         .load_byte (ctrl.data),
         .next_byte (next_byte),
         .held_byte (held[i])
      );
   end

   assign head_byte = held[0];

endmodule

// ===== design/printable_run_extractor.sv =====
// top level of the printable run extractor: sequencer, offset counter, output register
// depends on pre_pkg, pre_if, pre_chain and printable_run_extractor_macros.svh
//
// Passes on runs of printable bytes (0x20..0x7E and tab) at least min_len long,
// a newline after each reported run, and optionally a start-offset record before
// it. A byte is taken when the output register is free. The byte that brings a
// run to min_len starts a replay of the held bytes out of the cell chain, one per
// cycle while the output register is free; an enabled start-offset record leaves
// the output register as the first held byte enters it, so it does not hold up
// the replay. No input is taken during the replay. An output stall holds both
// input and replay. End of stream restarts the offset count at zero.
`include "printable_run_extractor_macros.svh"

module printable_run_extractor
   import pre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pre_req_if.sink               req_chan,
   pre_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic {S_IDLE, S_REPLAY} state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       run_count_ff, run_count_in;
   logic [CNT_W-1:0]       rep_cnt_ff, rep_cnt_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [MIN_LEN_W-1:0]   min_len_ff;
   logic                   offset_en_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic [OUT_OFF_W-1:0]   rsp_off_ff, rsp_off_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   rsp_free;
   logic                   req_take;
   logic [CNT_W-1:0]       eff_min;
   logic [CNT_W-1:0]       run_inc;
   logic [CNT_W-1:0]       rep_last_idx;
   logic                   rep_done;
   logic                   run_reported;
   logic [OFFSET_BITS-1:0] start_pos;
   logic [OFFSET_BITS+OUT_OFF_W-1:0] start_ext;
   logic [7:0]             head_byte;
   chain_ctrl_type         chain_ctrl;

   // effective minimum: zero acts as one, clamp to the chain length
   always_comb begin
      if (min_len_ff == '0) begin
         eff_min = CNT_W'(1);
      end else if (int'(min_len_ff) > MAX_MIN_LEN) begin
         eff_min = CNT_W'(MAX_MIN_LEN);
      end else begin
         eff_min = CNT_W'(min_len_ff);
      end
   end

   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;
   assign req_take     = req_chan.valid && req_chan.ready;
   assign run_inc      = run_count_ff + CNT_W'(1);
   assign rep_last_idx = run_count_ff - CNT_W'(1);
   assign rep_done     = (rep_cnt_ff == rep_last_idx);
   assign run_reported = (run_count_ff >= eff_min);
   assign start_pos    = pos_ff - OFFSET_BITS'(eff_min) + OFFSET_BITS'(1);
   assign start_ext    = {{OUT_OFF_W{1'b0}}, start_pos};

   // sequencer next state, chain control and output register loading
   always_comb begin
      state_in     = state_ff;
      run_count_in = run_count_ff;
      rep_cnt_in   = rep_cnt_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_last_in  = rsp_last_ff;

      chain_ctrl.load   = 1'b0;
      chain_ctrl.shift  = 1'b0;
      chain_ctrl.wr_idx = run_count_ff[IDX_W-1:0];
      chain_ctrl.len    = run_count_ff;
      chain_ctrl.data   = req_chan.byte_value;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_chan.op == OP_EOS) begin
                  // end of stream: close a reported run, restart offsets
                  if (run_reported) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_CHAR;
                     rsp_char_in  = CHAR_NL;
                     rsp_off_in   = '0;
                     rsp_last_in  = 1'b1;
                  end
                  run_count_in = '0;
                  pos_in       = '0;
               end else begin
                  pos_in = pos_ff + OFFSET_BITS'(1);
                  if (is_printable(req_chan.byte_value)) begin
                     if (!run_reported) begin
                        // hold the byte; replay once the run qualifies
                        chain_ctrl.load = 1'b1;
                        run_count_in    = run_inc;
                        if (run_inc == eff_min) begin
                           state_in   = S_REPLAY;
                           rep_cnt_in = '0;
                           if (offset_en_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_kind_in  = KIND_OFFSET;
                              rsp_char_in  = '0;
                              rsp_off_in   = start_ext[OUT_OFF_W-1:0];
                              rsp_last_in  = 1'b0;
                           end
                        end
                     end else begin
                        // run already reported: pass straight through
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_CHAR;
                        rsp_char_in  = req_chan.byte_value;
                        rsp_off_in   = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end else begin
                     // run ends on a non-printable byte
                     if (run_reported) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_CHAR;
                        rsp_char_in  = CHAR_NL;
                        rsp_off_in   = '0;
                        rsp_last_in  = 1'b1;
                     end
                     run_count_in = '0;
                  end
               end
            end
         end
         S_REPLAY: begin
            // one held byte per free output slot, rotating the chain
            if (rsp_free) begin
               chain_ctrl.shift = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_CHAR;
               rsp_char_in      = head_byte;
               rsp_off_in       = '0;
               rsp_last_in      = rep_done;
               rep_cnt_in       = rep_cnt_ff + CNT_W'(1);
               if (rep_done) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, counters, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_count_ff <= '0;
         rep_cnt_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_len_ff   <= MIN_LEN_RESET;
         offset_en_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_count_ff <= run_count_in;
         rep_cnt_ff   <= rep_cnt_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_LEN:   min_len_ff   <= csr_wdata[MIN_LEN_W-1:0];
               CSR_OFFSET_EN: offset_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_last_ff <= rsp_last_in;
   end

   // held bytes of the current run
   pre_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .head_byte (head_byte)
   );

   // channel wiring
   assign req_chan.ready        = (state_ff == S_IDLE) && rsp_free;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.char_out     = rsp_char_ff;
   assign rsp_chan.start_offset = rsp_off_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // checks
   `PRE_ASSERT(a_take_only_idle, req_chan.valid && req_chan.ready, state_ff == S_IDLE)
   `PRE_ASSERT(a_replay_in_run, state_ff == S_REPLAY, rep_cnt_ff < run_count_ff)
   `PRE_ASSERT(a_offset_not_last, rsp_valid_ff && (rsp_kind_ff == KIND_OFFSET), !rsp_last_ff)
   `PRE_ASSERT_NEXT(a_replay_ends, state_ff == S_REPLAY && rsp_free && rep_done, state_ff == S_IDLE)

endmodule
